@@ src/bpc_pkg.sv @@
// Shared types, constants and helpers for the pressure compensation pipeline.
// Used by every module under src; no dependencies.
`default_nettype none
package bpc_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 64;
    localparam int DivBits  = 32;

    localparam logic [CfgIdxW-1:0] REG_CAL_A = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CAL_B = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CAL_C = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_OSS   = 2'd3;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_K1        = 32'd3038;
    localparam logic [31:0] C_K2        = 32'd7357;
    localparam logic [31:0] C_K3        = 32'd3791;
    localparam logic [31:0] C_P_SCALE   = 32'd50000;
    localparam logic [31:0] C_HALF      = 32'd32768;
    localparam logic [31:0] C_SIGN      = 32'h8000_0000;
    localparam logic [15:0] C_ONES16    = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CAL  = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mb;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_cal;

    typedef struct packed {
        logic [31:0] word;
        logic [23:0] up;
        logic [15:0] temp;
        logic        neg;
        logic        zero1;
        logic        zero2;
        logic        dbl;
    } t_div_side;

    function automatic logic [31:0] f_asr(input logic [31:0] v, input int s);
        f_asr = $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] f_sext(input logic [15:0] v);
        f_sext = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] f_zext(input logic [15:0] v);
        f_zext = {16'd0, v};
    endfunction

    function automatic logic [15:0] f_sat16(input logic [31:0] v);
        if (!v[31] && (v[30:15] != 16'd0)) begin
            f_sat16 = 16'h7FFF;
        end else if (v[31] && (v[30:15] != 16'hFFFF)) begin
            f_sat16 = 16'h8000;
        end else begin
            f_sat16 = v[15:0];
        end
    endfunction

    function automatic logic [20:0] f_sat21(input logic [31:0] v);
        if (!v[31] && (v[30:20] != 11'd0)) begin
            f_sat21 = 21'h0F_FFFF;
        end else if (v[31] && (v[30:20] != 11'h7FF)) begin
            f_sat21 = 21'h10_0000;
        end else begin
            f_sat21 = v[20:0];
        end
    endfunction

    function automatic logic f_bad(input logic [15:0] v);
        f_bad = (v == 16'd0) || (v == C_ONES16);
    endfunction

endpackage
`default_nettype wire

@@ src/bpc_div.sv @@
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Carries a bpc_pkg::t_div_side sideband alongside each transfer.
`default_nettype none
module bpc_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  wire [31:0]           i_num,
    input  wire [31:0]           i_den,
    input  bpc_pkg::t_div_side   i_side,
    output logic                 o_vld,
    output logic [31:0]          o_quo,
    output bpc_pkg::t_div_side   o_side
);
    import bpc_pkg::*;

    logic [31:0] r_rem  [0:DivBits];
    logic [31:0] r_num  [0:DivBits];
    logic [31:0] r_quo  [0:DivBits];
    logic [31:0] r_den  [0:DivBits];
    t_div_side   r_side [0:DivBits];
    logic        r_vld  [0:DivBits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_rem[0]  <= 32'd0;
            r_num[0]  <= i_num;
            r_quo[0]  <= 32'd0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < DivBits; g++) begin : g_stage
        logic [32:0] w_trial;
        assign w_trial = {r_rem[g], r_num[g][31]} - {1'b0, r_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                if (!w_trial[32]) begin
                    r_rem[g+1] <= w_trial[31:0];
                end else begin
                    r_rem[g+1] <= {r_rem[g][30:0], r_num[g][31]};
                end
                r_quo[g+1]  <= {r_quo[g][30:0], ~w_trial[32]};
                r_num[g+1]  <= {r_num[g][30:0], 1'b0};
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[DivBits];
    assign o_quo  = r_quo[DivBits];
    assign o_side = r_side[DivBits];

endmodule
`default_nettype wire

@@ src/bpc_temp.sv @@
// Temperature front end: raw word minus ac6 times ac5, then divider operands for mc<<11 / (x1+md).
// Depends on bpc_pkg; feeds the first bpc_div.
`default_nettype none
module bpc_temp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  wire [15:0]           i_ut,
    input  wire [23:0]           i_up,
    input  bpc_pkg::t_cal        i_cal,
    output logic                 o_vld,
    output logic [31:0]          o_num,
    output logic [31:0]          o_den,
    output bpc_pkg::t_div_side   o_side
);
    import bpc_pkg::*;

    logic        r_s1_vld;
    logic [31:0] r_s1_m;
    logic [23:0] r_s1_up;
    logic [31:0] w_x1;
    logic [31:0] w_den;
    logic [31:0] w_num;
    logic [3:0]  w_shift;

    assign w_shift = 4'd8 - {2'd0, i_cal.oss};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
        end
        if (i_en) begin
            r_s1_m  <= ({16'd0, i_ut} - f_zext(i_cal.ac6)) * f_zext(i_cal.ac5);
            r_s1_up <= i_up >> w_shift;
        end
    end

    assign w_x1  = f_asr(r_s1_m, 15);
    assign w_den = w_x1 + f_sext(i_cal.md);
    assign w_num = f_sext(i_cal.mc) << 11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_s1_vld;
        end
        if (i_en) begin
            o_num        <= w_num[31] ? (32'd0 - w_num) : w_num;
            o_den        <= w_den[31] ? (32'd0 - w_den) : w_den;
            o_side.word  <= w_x1;
            o_side.up    <= r_s1_up;
            o_side.temp  <= 16'd0;
            o_side.neg   <= w_num[31] ^ w_den[31];
            o_side.zero1 <= (w_den == 32'd0);
            o_side.zero2 <= 1'b0;
            o_side.dbl   <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ src/bpc_press.sv @@
// Pressure middle section: b5, temperature, b3, b4, b7 and divider operands for p.
// Depends on bpc_pkg; sits between the two bpc_div instances.
`default_nettype none
module bpc_press (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  wire [31:0]           i_quo,
    input  bpc_pkg::t_div_side   i_side,
    input  bpc_pkg::t_cal        i_cal,
    output logic                 o_vld,
    output logic [31:0]          o_num,
    output logic [31:0]          o_den,
    output bpc_pkg::t_div_side   o_side
);
    import bpc_pkg::*;

    logic [5:0]  r_vld;
    logic [15:0] r_t    [3:8];
    logic [23:0] r_up   [3:6];
    logic        r_z1   [3:8];
    logic [31:0] r_b6;
    logic [31:0] r_sq_raw, r_pa, r_pb;
    logic [31:0] r_m1, r_m2, r_x2, r_x1b;
    logic [31:0] r_b3, r_x3b;
    logic [31:0] r_b4_7, r_b4_8, r_diff;
    logic [31:0] r_b7;

    logic [31:0] w_x2, w_b5, w_sq, w_x3, w_b3, w_x3b;

    assign w_x2  = i_side.zero1 ? 32'd0 : (i_side.neg ? (32'd0 - i_quo) : i_quo);
    assign w_b5  = i_side.word + w_x2;
    assign w_sq  = f_asr(r_sq_raw, 12);
    assign w_x3  = f_asr(r_m2, 11) + r_x2;
    assign w_b3  = f_asr((((f_sext(i_cal.ac1) << 2) + w_x3) << i_cal.oss) + 32'd2, 2);
    assign w_x3b = f_asr(r_x1b + f_asr(r_m1, 16) + 32'd2, 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
            o_vld <= r_vld[5];
        end
        if (i_en) begin
            r_t[3]  <= f_sat16(f_asr(w_b5 + 32'd8, 4));
            r_b6    <= w_b5 - C_B6_OFFSET;
            r_up[3] <= i_side.up;
            r_z1[3] <= i_side.zero1;
            for (int k = 4; k <= 8; k++) begin
                r_t[k]  <= r_t[k-1];
                r_z1[k] <= r_z1[k-1];
            end
            for (int k = 4; k <= 6; k++) begin
                r_up[k] <= r_up[k-1];
            end

            r_sq_raw <= r_b6 * r_b6;
            r_pa     <= f_sext(i_cal.ac2) * r_b6;
            r_pb     <= f_sext(i_cal.ac3) * r_b6;

            r_m2  <= f_sext(i_cal.b2) * w_sq;
            r_m1  <= f_sext(i_cal.b1) * w_sq;
            r_x2  <= f_asr(r_pa, 11);
            r_x1b <= f_asr(r_pb, 13);

            r_b3  <= w_b3;
            r_x3b <= w_x3b;

            r_b4_7 <= (f_zext(i_cal.ac4) * (r_x3b + C_HALF)) >> 15;
            r_diff <= {8'd0, r_up[6]} - r_b3;

            r_b7   <= r_diff * (C_P_SCALE >> i_cal.oss);
            r_b4_8 <= r_b4_7;

            o_num        <= r_b7[31] ? r_b7 : (r_b7 << 1);
            o_den        <= r_b4_8;
            o_side.word  <= 32'd0;
            o_side.up    <= 24'd0;
            o_side.temp  <= r_t[8];
            o_side.neg   <= 1'b0;
            o_side.zero1 <= r_z1[8];
            o_side.zero2 <= (r_b4_8 == 32'd0);
            o_side.dbl   <= r_b7[31];
        end
    end

endmodule
`default_nettype wire

@@ src/bpc_corr.sv @@
// Pressure back end: quotient fix-up, second-order correction, saturation and output register.
// Depends on bpc_pkg; fed by the second bpc_div.
`default_nettype none
module bpc_corr (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  wire [31:0]           i_quo,
    input  bpc_pkg::t_div_side   i_side,
    input  wire                  i_bad_cal,
    output logic                 o_vld,
    output logic [15:0]          o_temp,
    output logic [20:0]          o_pres,
    output logic [1:0]           o_status
);
    import bpc_pkg::*;

    logic [2:0]  r_vld;
    logic [15:0] r_t  [10:12];
    logic        r_dz [10:12];
    logic [31:0] r_p  [10:12];
    logic [31:0] r_sq, r_m7, r_mm, r_x2;
    logic [31:0] w_ps, w_pf;
    t_status     w_status;

    assign w_ps = f_asr(r_p[10], 8);
    assign w_pf = r_p[12] + f_asr(f_asr(r_mm, 16) + r_x2 + C_K3, 4);

    always_comb begin
        if (i_bad_cal) begin
            w_status = ST_BAD_CAL;
        end else if (r_dz[12]) begin
            w_status = ST_DIV_ZERO;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
            o_vld <= r_vld[2];
        end
        if (i_en) begin
            if (i_side.zero2) begin
                r_p[10] <= 32'd0;
            end else if (i_side.dbl) begin
                r_p[10] <= i_quo << 1;
            end else begin
                r_p[10] <= i_quo;
            end
            r_t[10]  <= i_side.temp;
            r_dz[10] <= i_side.zero1 | i_side.zero2;
            for (int k = 11; k <= 12; k++) begin
                r_p[k]  <= r_p[k-1];
                r_t[k]  <= r_t[k-1];
                r_dz[k] <= r_dz[k-1];
            end

            r_sq <= w_ps * w_ps;
            r_m7 <= 32'd0 - C_K2 * r_p[10];

            r_mm <= r_sq * C_K1;
            r_x2 <= f_asr(r_m7, 16);

            o_temp   <= r_t[12];
            o_pres   <= f_sat21(w_pf);
            o_status <= w_status;
        end
    end

endmodule
`default_nettype wire

@@ src/barometric_pressure_compensation_unit.sv @@
// The pipeline depth comes mostly from the two 32-stage dividers.
// Throughput: one transfer per cycle; a downstream stall while a result is valid freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and the calibration registers.
// Top level: configuration registers, stall control and the pipeline sections.
// Depends on bpc_pkg, bpc_temp, bpc_div, bpc_press, bpc_corr.
`default_nettype none
module barometric_pressure_compensation_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [15:0]                   i_raw_temperature,
    input  wire [23:0]                   i_raw_pressure,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [15:0]           o_temperature_tenths,
    output logic signed [20:0]           o_pressure_pa,
    output logic [1:0]                   o_status,
    input  wire                          i_cfg_we,
    input  wire [bpc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire [bpc_pkg::CfgDataW-1:0]  i_cfg_data
);
    import bpc_pkg::*;

    logic [63:0] r_cal_a, r_cal_b;
    logic [47:0] r_cal_c;
    logic [1:0]  r_oss;
    t_cal        w_cal;
    logic        w_en, w_bad;

    logic        w_t_vld, w_d1_vld, w_p_vld, w_d2_vld;
    logic [31:0] w_t_num, w_t_den, w_d1_quo, w_p_num, w_p_den, w_d2_quo;
    t_div_side   w_t_side, w_d1_side, w_p_side, w_d2_side;
    logic [15:0] w_temp;
    logic [20:0] w_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAL_A: r_cal_a <= i_cfg_data;
                REG_CAL_B: r_cal_b <= i_cfg_data;
                REG_CAL_C: r_cal_c <= i_cfg_data[47:0];
                REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_cal.ac1 = r_cal_a[63:48];
    assign w_cal.ac2 = r_cal_a[47:32];
    assign w_cal.ac3 = r_cal_a[31:16];
    assign w_cal.ac4 = r_cal_a[15:0];
    assign w_cal.ac5 = r_cal_b[63:48];
    assign w_cal.ac6 = r_cal_b[47:32];
    assign w_cal.b1  = r_cal_b[31:16];
    assign w_cal.b2  = r_cal_b[15:0];
    assign w_cal.mb  = r_cal_c[47:32];
    assign w_cal.mc  = r_cal_c[31:16];
    assign w_cal.md  = r_cal_c[15:0];
    assign w_cal.oss = r_oss;

    assign w_bad = f_bad(w_cal.ac1) | f_bad(w_cal.ac2) | f_bad(w_cal.ac3) |
                   f_bad(w_cal.ac4) | f_bad(w_cal.ac5) | f_bad(w_cal.ac6) |
                   f_bad(w_cal.b1)  | f_bad(w_cal.b2)  | f_bad(w_cal.mb)  |
                   f_bad(w_cal.mc)  | f_bad(w_cal.md);

    // advance unless a finished result is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_ut    (i_raw_temperature),
        .i_up    (i_raw_pressure),
        .i_cal   (w_cal),
        .o_vld   (w_t_vld),
        .o_num   (w_t_num),
        .o_den   (w_t_den),
        .o_side  (w_t_side)
    );

    bpc_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_t_vld),
        .i_num   (w_t_num),
        .i_den   (w_t_den),
        .i_side  (w_t_side),
        .o_vld   (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d1_vld),
        .i_quo   (w_d1_quo),
        .i_side  (w_d1_side),
        .i_cal   (w_cal),
        .o_vld   (w_p_vld),
        .o_num   (w_p_num),
        .o_den   (w_p_den),
        .o_side  (w_p_side)
    );

    bpc_div u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_p_vld),
        .i_num   (w_p_num),
        .i_den   (w_p_den),
        .i_side  (w_p_side),
        .o_vld   (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    bpc_corr u_corr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_d2_vld),
        .i_quo     (w_d2_quo),
        .i_side    (w_d2_side),
        .i_bad_cal (w_bad),
        .o_vld     (o_valid),
        .o_temp    (w_temp),
        .o_pres    (w_pres),
        .o_status  (o_status)
    );

    assign o_temperature_tenths = w_temp;
    assign o_pressure_pa        = w_pres;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for barometric_pressure_compensation_unit: drives raw temperature and pressure
// words under random idling, predicts each result and checks it field by field.
// Depends on bpc_pkg and the RTL under src.
`timescale 1ns / 1ps

class comp_scoreboard;
    logic [15:0] exp_temp[$];
    logic [20:0] exp_press[$];
    logic [1:0]  exp_stat[$];
    int          mismatches;

    function void note_transfer(logic [15:0] t, logic [20:0] p, logic [1:0] s);
        exp_temp.push_back(t);
        exp_press.push_back(p);
        exp_stat.push_back(s);
    endfunction

    function void check_result(logic [15:0] t, logic [20:0] p, logic [1:0] s);
        logic [15:0] et;
        logic [20:0] ep;
        logic [1:0]  es;
        if (exp_temp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result t=%h p=%h s=%0d", t, p, s);
            return;
        end
        et = exp_temp.pop_front();
        ep = exp_press.pop_front();
        es = exp_stat.pop_front();
        if (t !== et || p !== ep || s !== es) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp t=%h p=%h s=%0d, got t=%h p=%h s=%0d",
                         et, ep, es, t, p, s);
        end
    endfunction

    function int pending();
        return exp_temp.size();
    endfunction
endclass

module tb;
    import bpc_pkg::*;

    localparam int LATENCY = 79;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_raw_temperature = '0;
    logic [23:0] i_raw_pressure = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [15:0] o_temperature_tenths;
    logic signed [20:0] o_pressure_pa;
    logic [1:0]  o_status;
    logic        i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    logic [63:0] cal_a, cal_b;
    logic [47:0] cal_c;
    logic [1:0]  oss;
    int          send_idle_pct, recv_idle_pct;
    int          cycles;
    comp_scoreboard sb;

    barometric_pressure_compensation_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] asr(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic is_bad(logic [15:0] v);
        return v == 16'h0000 || v == 16'hFFFF;
    endfunction

    task automatic compensate(input logic [15:0] ut_raw, input logic [23:0] up_raw,
                              output logic [15:0] t_out, output logic [20:0] p_out,
                              output t_status st);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b5, b6, b3, b4, b7, p, t, den, sq;
        ac1 = sx(cal_a[63:48]); ac2 = sx(cal_a[47:32]); ac3 = sx(cal_a[31:16]);
        ac4 = {16'd0, cal_a[15:0]}; ac5 = {16'd0, cal_b[63:48]};
        ac6 = {16'd0, cal_b[47:32]};
        b1 = sx(cal_b[31:16]); b2 = sx(cal_b[15:0]);
        mc = sx(cal_c[31:16]); md = sx(cal_c[15:0]);
        ut = {16'd0, ut_raw};
        up = {8'd0, up_raw} >> (8 - oss);
        st = ST_OK;
        if (is_bad(cal_a[63:48]) || is_bad(cal_a[47:32]) || is_bad(cal_a[31:16]) ||
            is_bad(cal_a[15:0]) || is_bad(cal_b[63:48]) || is_bad(cal_b[47:32]) ||
            is_bad(cal_b[31:16]) || is_bad(cal_b[15:0]) || is_bad(cal_c[47:32]) ||
            is_bad(cal_c[31:16]) || is_bad(cal_c[15:0]))
            st = ST_BAD_CAL;
        x1 = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) begin
            x2 = 0;
            if (st == ST_OK) st = ST_DIV_ZERO;
        end else begin
            x2 = 32'(longint'($signed(mc << 11)) / longint'($signed(den)));
        end
        b5 = x1 + x2;
        t = asr(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b4 == 0) begin
            p = 0;
            if (st == ST_OK) st = ST_DIV_ZERO;
        end else if (b7 < 32'h8000_0000) begin
            p = (b7 * 32'd2) / b4;
        end else begin
            p = (b7 / b4) * 32'd2;
        end
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr(32'd0 - 32'd7357 * p, 16);
        p = p + asr(x1 + x2 + 32'd3791, 4);
        if ($signed(t) > 32767) t_out = 16'h7FFF;
        else if ($signed(t) < -32768) t_out = 16'h8000;
        else t_out = t[15:0];
        if ($signed(p) > 1048575) p_out = 21'h0F_FFFF;
        else if ($signed(p) < -1048576) p_out = 21'h10_0000;
        else p_out = p[20:0];
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_CAL_A: cal_a = data;
            REG_CAL_B: cal_b = data;
            REG_CAL_C: cal_c = data[47:0];
            default: oss = data[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
                            input logic [47:0] c, input logic [1:0] o);
        write_reg(REG_CAL_A, a);
        write_reg(REG_CAL_B, b);
        write_reg(REG_CAL_C, {16'd0, c});
        write_reg(REG_OSS, {62'd0, o});
    endtask

    task automatic send_pair(input logic [15:0] ut, input logic [23:0] up);
        logic [15:0] t;
        logic [20:0] p;
        t_status st;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        compensate(ut, up, t, p, st);
        sb.note_transfer(t, p, st);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0)
                send_pair(16'($urandom), 24'($urandom));
            else
                send_pair(16'($urandom_range(20000, 36000)), 24'($urandom_range(0, 24'hFFFFFF)));
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_temperature_tenths, o_pressure_pa, o_status);
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL barometric_pressure_compensation_unit");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        cal_a = '0; cal_b = '0; cal_c = '0; oss = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all-zero calibration after reset: invalid coefficients and zero divisors
        send_pair(16'h0000, 24'h000000);
        send_pair(16'hFFFF, 24'hFFFFFF);
        drain();

        // typical datasheet calibration
        load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153, 16'd6190, 16'd4},
                 {-16'sd32768, -16'sd8711, 16'd2868}, 2'd0);
        send_pair(16'd27898, 24'd23843 << 8);
        send_pair(16'h0000, 24'h000000);
        send_pair(16'hFFFF, 24'hFFFFFF);
        send_pair(16'h8000, 24'h800000);
        send_pair(16'h7FFF, 24'h7FFFFF);
        drain();
        write_reg(REG_OSS, 64'd3);
        send_pair(16'd27898, 24'h5D2300);
        send_pair(16'h0000, 24'hFFFFFF);
        send_pair(16'hFFFF, 24'h000000);
        drain();

        // all-ones md marks the calibration invalid
        load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153, 16'd6190, 16'd4},
                 {-16'sd32768, -16'sd8711, 16'hFFFF}, 2'd1);
        send_pair(16'd23153, 24'h400000);
        drain();
        // zero temperature divisor: ac6 = ut so x1 = 0, md = 0 is invalid, so use x1 = -md
        load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                 {16'h7FFF, 16'd1000, 16'd6190, 16'd4},
                 {-16'sd32768, -16'sd8711, 16'd1}, 2'd2);
        send_pair(16'd998, 24'h123456);
        send_pair(16'd999, 24'h654321);
        send_pair(16'd1000, 24'hABCDEF);
        drain();
        // extreme coefficients; these edge-case raw words may hit b4 = 0
        load_cal({16'h7FFF, 16'h8000, 16'h8001, 16'h0001},
                 {16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000},
                 {16'h0001, 16'h7FFF, 16'h8000}, 2'd3);
        send_pair(16'h0000, 24'h000000);
        send_pair(16'hFFFF, 24'hFFFFFF);
        send_pair(16'h1234, 24'h000001);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph % 3 == 0)
                load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153, 16'd6190, 16'd4},
                         {-16'sd32768, -16'sd8711, 16'd2868}, 2'(ph));
            else
                load_cal({$urandom, $urandom}, {$urandom, $urandom},
                         {16'($urandom), $urandom}, 2'($urandom_range(3)));
            random_phase(105, ph < 3 ? 23 : (ph < 6 ? 66 : 0),
                         ph < 3 ? 66 : (ph < 6 ? 23 : 0));
        end

        if (sb.mismatches == 0)
            $display("PASS barometric_pressure_compensation_unit");
        else
            $display("FAIL barometric_pressure_compensation_unit");
        $finish;
    end
endmodule
